// ===== rtl/core/perq_pkg.sv =====
package perq_pkg;

  // Built ring depth and fixed field widths
  localparam int PERQ_DEPTH     = 16;
  localparam int PERQ_NUM_TYPES = 12;
  localparam int CAP_W          = 5;
  localparam int MASK_W         = 12;
  localparam int FILL_W         = 5;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  // Backpressure threshold: depth*BP_NUM >= capacity*BP_DEN
  localparam int BP_NUM = 100;
  localparam int BP_DEN = 75;

  // Register reset values
  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [MASK_W-1:0] MASK_RESET = 12'hFFF;

  // Register indexes (paddr bit 2)
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_MASK     = 1'b1;

  // Event types that carry a non-normal default priority
  localparam logic [3:0] TYPE_ALERT   = 4'd6;
  localparam logic [3:0] TYPE_OUTPUT  = 4'd7;
  localparam logic [3:0] TYPE_STORAGE = 4'd8;
  localparam logic [3:0] TYPE_METRICS = 4'd9;
  localparam logic [3:0] TYPE_RELOAD  = 4'd10;
  localparam logic [3:0] TYPE_HEALTH  = 4'd11;

  // Priority codes
  localparam logic [2:0] PRI_UNSET    = 3'd0;
  localparam logic [2:0] PRI_LOW      = 3'd1;
  localparam logic [2:0] PRI_NORMAL   = 3'd2;
  localparam logic [2:0] PRI_HIGH     = 3'd3;
  localparam logic [2:0] PRI_CRITICAL = 3'd4;

  typedef enum logic {
    CMD_PUBLISH = 1'b0,
    CMD_POP     = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_QUEUED  = 3'd0,
    STAT_IGNORED = 3'd1,
    STAT_DROPPED = 3'd2,
    STAT_POPPED  = 3'd3,
    STAT_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RD_BEST,
    ST_RD_HEAD,
    ST_WR_BEST,
    ST_WR_HEAD
  } perq_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  event_type;
    logic [2:0]  request_priority;
    logic [31:0] event_handle;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] out_id;
    logic [31:0] out_handle;
    logic [3:0]  out_type;
    logic [2:0]  out_priority;
    logic        out_backpressure;
    logic [31:0] drops_before;
    logic [4:0]  out_depth;
  } out_t;

  typedef struct packed {
    logic [CAP_W-1:0]  capacity;
    logic [MASK_W-1:0] mask;
  } cfg_t;

  // Slot contents: id in the upper half, handle in the lower half
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] handle;
  } tag_t;

  typedef struct packed {
    logic [31:0] snap;
    logic        bp;
    logic [2:0]  pri;
    logic [3:0]  etype;
  } meta_t;

  // Default priority of an event type
  function automatic logic [2:0] type_default(input logic [3:0] t);
    logic [2:0] p;
    case (t) inside
      TYPE_ALERT:                              p = PRI_HIGH;
      TYPE_RELOAD, TYPE_HEALTH:                p = PRI_CRITICAL;
      TYPE_OUTPUT, TYPE_STORAGE, TYPE_METRICS: p = PRI_LOW;
      default:                                 p = PRI_NORMAL;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/perq_ram.sv =====
module perq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/perq_core.sv =====
module perq_core import perq_pkg::*; #(
  parameter int DEPTH = PERQ_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  input  cfg_t cfg,
  output logic out_strobe,
  output out_t out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int AW = ((PW > CAP_W) ? PW : CAP_W) + 1;
  localparam int BW = AW + 7;

  perq_state_t state_r, state_nxt;
  in_t         item_r, item_nxt;
  logic [PW-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [PW-1:0]     pos_r, pos_nxt, cmp_pos_r, cmp_pos_nxt, best_r, best_nxt;
  logic [FW-1:0]     fill_r, fill_nxt, iss_r, iss_nxt, rcv_r, rcv_nxt;
  logic [31:0]       last_id_r, last_id_nxt, drop_r, drop_nxt;
  logic [2:0]        best_pri_r, best_pri_nxt;
  logic              pend_r, pend_nxt;
  tag_t              pop_tag_r, pop_tag_nxt;
  meta_t             pop_meta_r, pop_meta_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              wr_en;
  logic [PW-1:0]     wr_addr, rd_addr;
  tag_t              tag_wdata, tag_rdata;
  meta_t             meta_wdata, meta_rdata;

  logic [AW-1:0]     cap_ext, cap_eff;
  logic [15:0]       mask_ext;
  logic              ignore, full, bp;
  logic [2:0]        pri;
  logic [31:0]       new_id;

  // Advance a ring position, wrapping at the effective capacity
  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [AW-1:0] c);
    logic [AW-1:0] p1;
    p1 = AW'(p) + AW'(1);
    return (p1 >= c) ? '0 : p1[PW-1:0];
  endfunction

  perq_ram #(.WIDTH($bits(tag_t)), .DEPTH(DEPTH)) u_tag_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (tag_wdata),
    .rd_addr (rd_addr),
    .rd_data (tag_rdata)
  );

  perq_ram #(.WIDTH($bits(meta_t)), .DEPTH(DEPTH)) u_meta_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (meta_wdata),
    .rd_addr (rd_addr),
    .rd_data (meta_rdata)
  );

  // Clamp capacity to 1..DEPTH
  always_comb begin
    cap_ext = AW'(cfg.capacity);
    if (cap_ext == '0) begin
      cap_eff = AW'(1);
    end else if (cap_ext > AW'(DEPTH)) begin
      cap_eff = AW'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // Publish decode: filter, resolve priority, id, full and backpressure tests
  always_comb begin
    mask_ext = 16'(cfg.mask);
    ignore   = ({2'b00, item_r.event_type} >= 6'(PERQ_NUM_TYPES)) ||
               !mask_ext[item_r.event_type];
    pri      = (item_r.request_priority == PRI_UNSET ||
                item_r.request_priority > PRI_CRITICAL) ?
               type_default(item_r.event_type) : item_r.request_priority;
    new_id   = last_id_r + 32'd1;
    full     = AW'(fill_r) >= cap_eff;
    bp       = (BW'(fill_r) * BW'(BP_NUM)) >= (BW'(cap_eff) * BW'(BP_DEN));
  end

  // Sequencer: next state, datapath updates and memory control
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    last_id_nxt    = last_id_r;
    drop_nxt       = drop_r;
    pos_nxt        = pos_r;
    cmp_pos_nxt    = cmp_pos_r;
    best_nxt       = best_r;
    best_pri_nxt   = best_pri_r;
    iss_nxt        = iss_r;
    rcv_nxt        = rcv_r;
    pend_nxt       = pend_r;
    pop_tag_nxt    = pop_tag_r;
    pop_meta_nxt   = pop_meta_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    wr_addr        = tail_r;
    rd_addr        = pos_r;
    tag_wdata      = '{id: new_id, handle: item_r.event_handle};
    meta_wdata     = '{snap: drop_r, bp: bp, pri: pri, etype: item_r.event_type};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (item_r.cmd == CMD_PUBLISH) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
          if (ignore) begin
            out_data_nxt           = '0;
            out_data_nxt.status    = STAT_IGNORED;
            out_data_nxt.out_depth = FILL_W'(fill_r);
          end else begin
            last_id_nxt                   = new_id;
            out_data_nxt.out_id           = new_id;
            out_data_nxt.out_handle       = '0;
            out_data_nxt.out_type         = item_r.event_type;
            out_data_nxt.out_priority     = pri;
            out_data_nxt.out_backpressure = bp;
            out_data_nxt.drops_before     = drop_r;
            if (full) begin
              drop_nxt               = drop_r + 32'd1;
              out_data_nxt.status    = STAT_DROPPED;
              out_data_nxt.out_depth = FILL_W'(fill_r);
            end else begin
              // enqueue at the tail
              wr_en                  = 1'b1;
              wr_addr                = tail_r;
              tail_nxt               = adv(tail_r, cap_eff);
              fill_nxt               = fill_r + FW'(1);
              out_data_nxt.status    = STAT_QUEUED;
              out_data_nxt.out_depth = FILL_W'(fill_r + FW'(1));
            end
          end
        end else if (fill_r == '0) begin
          out_strobe_nxt      = 1'b1;
          out_data_nxt        = '0;
          out_data_nxt.status = STAT_EMPTY;
          state_nxt           = ST_IDLE;
        end else begin
          pos_nxt   = head_r;
          iss_nxt   = '0;
          rcv_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // compare the entry read last cycle against the best so far
        if (pend_r) begin
          if (rcv_r == '0 || meta_rdata.pri > best_pri_r) begin
            best_nxt     = cmp_pos_r;
            best_pri_nxt = meta_rdata.pri;
          end
          rcv_nxt = rcv_r + FW'(1);
          if (rcv_r + FW'(1) == fill_r) begin
            state_nxt = ST_RD_BEST;
          end
        end
        // issue the next read while entries remain
        if (iss_r < fill_r) begin
          rd_addr     = pos_r;
          pend_nxt    = 1'b1;
          cmp_pos_nxt = pos_r;
          pos_nxt     = adv(pos_r, cap_eff);
          iss_nxt     = iss_r + FW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end

      ST_RD_BEST: begin
        rd_addr   = best_r;
        state_nxt = ST_RD_HEAD;
      end

      ST_RD_HEAD: begin
        rd_addr      = head_r;
        pop_tag_nxt  = tag_rdata;
        pop_meta_nxt = meta_rdata;
        state_nxt    = ST_WR_BEST;
      end

      ST_WR_BEST: begin
        // move the head entry into the winner's slot
        wr_en      = 1'b1;
        wr_addr    = best_r;
        tag_wdata  = tag_rdata;
        meta_wdata = meta_rdata;
        state_nxt  = ST_WR_HEAD;
      end

      ST_WR_HEAD: begin
        // place the winner at the head, then emit and remove it
        wr_en                         = 1'b1;
        wr_addr                       = head_r;
        tag_wdata                     = pop_tag_r;
        meta_wdata                    = pop_meta_r;
        head_nxt                      = adv(head_r, cap_eff);
        fill_nxt                      = fill_r - FW'(1);
        out_strobe_nxt                = 1'b1;
        out_data_nxt.status           = STAT_POPPED;
        out_data_nxt.out_id           = pop_tag_r.id;
        out_data_nxt.out_handle       = pop_tag_r.handle;
        out_data_nxt.out_type         = pop_meta_r.etype;
        out_data_nxt.out_priority     = pop_meta_r.pri;
        out_data_nxt.out_backpressure = pop_meta_r.bp;
        out_data_nxt.drops_before     = pop_meta_r.snap;
        out_data_nxt.out_depth        = FILL_W'(fill_r - FW'(1));
        state_nxt                     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
      last_id_r    <= '0;
      drop_r       <= '0;
      iss_r        <= '0;
      rcv_r        <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      fill_r       <= fill_nxt;
      last_id_r    <= last_id_nxt;
      drop_r       <= drop_nxt;
      iss_r        <= iss_nxt;
      rcv_r        <= rcv_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    pos_r      <= pos_nxt;
    cmp_pos_r  <= cmp_pos_nxt;
    best_r     <= best_nxt;
    best_pri_r <= best_pri_nxt;
    pop_tag_r  <= pop_tag_nxt;
    pop_meta_r <= pop_meta_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ===== rtl/core/priority_event_ring_queue.sv =====
// Priority event ring queue.
// Command channel: drive in_data and raise start; the item is taken at the
// rising edge where start is high and busy is low. A publish (cmd 0) filters
// the type against subscriber_mask, resolves the priority, assigns an id and
// queues the event at the ring tail, or counts a drop when the ring is full.
// A pop (cmd 1) returns the highest-priority entry; a tie goes to the one nearest the head.
// Each item gives one result on out_data, shown for exactly one cycle with
// out_strobe high; the receiver cannot hold it off.
// Sequencing: a publish or a pop of an empty queue is decided in the EXEC state
// and its result is registered; no new item is taken until busy falls. A pop
// of a non-empty queue scans every held entry, one ring entry per cycle through
// the registered read port of the slot memory into a single priority comparator,
// then the head/winner swap takes two reads and two writes on that same port pair.
// Configuration: APB port, capacity at address 0, subscriber mask at 4;
// write only while no item is in flight.
// Reset (synchronous, rst_n low) empties the ring and clears the id and drop
// counters; capacity returns to 16 and the mask to all types.
module priority_event_ring_queue import perq_pkg::*; #(
  parameter int DEPTH = PERQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_strobe,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg_r, cfg_nxt;
  logic cfg_wr;

  // Register write decode
  always_comb begin
    cfg_wr  = psel && penable && pwrite;
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_CAPACITY: cfg_nxt.capacity = pwdata[CAP_W-1:0];
        REG_MASK:     cfg_nxt.mask     = pwdata[MASK_W-1:0];
        default:      cfg_nxt          = cfg_r;
      endcase
    end
  end

  // Register read mux
  always_comb begin
    unique case (paddr[2])
      REG_CAPACITY: prdata = APB_DW'(cfg_r.capacity);
      REG_MASK:     prdata = APB_DW'(cfg_r.mask);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity <= CAP_RESET;
      cfg_r.mask     <= MASK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign pready = 1'b1;

  perq_core #(.DEPTH(DEPTH)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/core/perq_chk.sv =====
module perq_chk import perq_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input out_t out_data
);

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("block not idle after reset");

  // An accepted item always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // Finishing an item always shows its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_strobe)
    else $error("work ended without a result");

  // Results never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two results in consecutive cycles");

  // An ignored publish carries nothing but the depth
  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == STAT_IGNORED) |->
      (out_data.out_id == '0 && out_data.out_handle == '0 &&
       out_data.out_type == '0 && out_data.out_priority == '0 &&
       !out_data.out_backpressure && out_data.drops_before == '0))
    else $error("ignored publish with non-zero fields");

endmodule

bind priority_event_ring_queue perq_chk u_perq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
